### src/pces_pkg.sv
// ----------------------------------------------------------------------------
// PCI config enumeration package
// Shared types and constants for the bus walk controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package pces_pkg;

  localparam logic [5:0]  BAR_FIRST = 6'h10;
  localparam logic [11:0] OFF_CMD   = 12'h004;
  localparam logic [11:0] OFF_HDR   = 12'h00C;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0] IO_MASK   = 32'hFFFF_FFFC;
  localparam logic [31:0] MEM_MASK  = 32'hFFFF_FFF0;
  localparam logic [15:0] VID_NONE  = 16'hFFFF;
  localparam logic [31:0] CMD_ENABLES = 32'h0000_0006;
  localparam logic [63:0] ALLOC_RESET = 64'h0000_0000_8000_0000;

  localparam logic [1:0] REG_SCAN_BUS   = 2'd0;
  localparam logic [1:0] REG_ECAM_BASE  = 2'd1;
  localparam logic [1:0] REG_ALLOC_BASE = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE, PH_DEV_VID, PH_DEV_HDR, PH_FN_VID, PH_BAR_READ, PH_PR_ORIG,
    PH_IO_SET, PH_IO_READ, PH_IO_REST, PH_M32_SET, PH_M32_READ, PH_M32_REST,
    PH_M64_HI, PH_M64_SETLO, PH_M64_SETHI, PH_M64_READLO, PH_M64_READHI,
    PH_M64_RESTLO, PH_M64_RESTHI, PH_AS_READ, PH_AS_WLO, PH_AS_TYPE,
    PH_AS_WHI, PH_CMD_READ, PH_CMD_WRITE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_FINISH = 2'd2
  } access_kind_t;

  typedef enum logic [2:0] {
    OSEL_ZERO, OSEL_HDR, OSEL_CMD, OSEL_BAR, OSEL_BAR4
  } off_sel_t;

  typedef enum logic [2:0] {
    WSEL_ZERO, WSEL_ONES, WSEL_SAVED_LO, WSEL_SAVED_HI, WSEL_ALIGN_LO,
    WSEL_ALIGN_HI, WSEL_CMD_OR
  } wsel_t;

  typedef struct packed {
    logic         start;
    logic         dev_next;
    logic         fn_next;
    logic         fn_clear;
    logic         mf_load;
    logic         bar_first;
    logic         bar_adv;
    logic         bar_step8;
    logic         save_low;
    logic         save_high;
    logic         size_io;
    logic         size_m32;
    logic         size_m64lo;
    logic         size_m64hi;
    logic         ptr_commit;
    logic         emit;
    logic         finish;
    access_kind_t kind;
    off_sel_t     osel;
    wsel_t        wsel;
  } cmd_t;

  typedef struct packed {
    logic vid_absent;
    logic data_zero;
    logic data_io;
    logic data_m64;
    logic hdr_multi;
    logic last_dev;
    logic last_fn;
    logic end4;
    logic end_saved;
    logic step8;
    logic size_nz;
  } stat_t;

endpackage
`default_nettype wire

### src/pces_ctrl.sv
// ----------------------------------------------------------------------------
// PCI config enumeration controller
// Phase machine that turns each completion word into datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none
module pces_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           act,
  input  wire logic           operation,
  input  wire pces_pkg::stat_t st,
  output pces_pkg::cmd_t      cmd
);
  import pces_pkg::*;

  phase_t phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (act) begin
      phase <= phase_next;
    end
  end

  always_comb begin
    logic adv4, advs, probe_done, commit, nfn, ndev, aend;
    cmd = '0;
    cmd.kind = KIND_READ;
    cmd.osel = OSEL_ZERO;
    cmd.wsel = WSEL_ZERO;
    phase_next = phase;
    adv4 = 1'b0;
    advs = 1'b0;
    probe_done = 1'b0;
    commit = 1'b0;
    nfn = 1'b0;
    ndev = 1'b0;
    aend = 1'b0;
    if (!operation) begin
      cmd.start = 1'b1;
      cmd.emit = 1'b1;
      phase_next = PH_DEV_VID;
    end else begin
      cmd.emit = 1'b1;
      case (phase)
        PH_DEV_VID: begin
          if (st.vid_absent) begin
            cmd.emit = 1'b0;
            ndev = 1'b1;
          end else begin
            cmd.osel = OSEL_HDR;
            phase_next = PH_DEV_HDR;
          end
        end
        PH_DEV_HDR: begin
          cmd.mf_load = 1'b1;
          cmd.fn_clear = 1'b1;
          phase_next = PH_FN_VID;
        end
        PH_FN_VID: begin
          if (st.vid_absent) begin
            cmd.emit = 1'b0;
            nfn = 1'b1;
          end else begin
            cmd.bar_first = 1'b1;
            cmd.osel = OSEL_BAR;
            phase_next = PH_BAR_READ;
          end
        end
        PH_BAR_READ: begin
          if (st.data_zero) begin
            cmd.emit = 1'b0;
            adv4 = 1'b1;
          end else begin
            cmd.osel = OSEL_BAR;
            phase_next = PH_PR_ORIG;
          end
        end
        PH_PR_ORIG: begin
          cmd.save_low = 1'b1;
          if (st.data_io) begin
            cmd.kind = KIND_WRITE;
            cmd.osel = OSEL_BAR;
            cmd.wsel = WSEL_ONES;
            phase_next = PH_IO_SET;
          end else if (st.data_m64) begin
            cmd.osel = OSEL_BAR4;
            phase_next = PH_M64_HI;
          end else begin
            cmd.kind = KIND_WRITE;
            cmd.osel = OSEL_BAR;
            cmd.wsel = WSEL_ONES;
            phase_next = PH_M32_SET;
          end
        end
        PH_IO_SET: begin
          cmd.osel = OSEL_BAR;
          phase_next = PH_IO_READ;
        end
        PH_IO_READ: begin
          cmd.size_io = 1'b1;
          cmd.kind = KIND_WRITE;
          cmd.osel = OSEL_BAR;
          cmd.wsel = WSEL_SAVED_LO;
          phase_next = PH_IO_REST;
        end
        PH_M32_SET: begin
          cmd.osel = OSEL_BAR;
          phase_next = PH_M32_READ;
        end
        PH_M32_READ: begin
          cmd.size_m32 = 1'b1;
          cmd.kind = KIND_WRITE;
          cmd.osel = OSEL_BAR;
          cmd.wsel = WSEL_SAVED_LO;
          phase_next = PH_M32_REST;
        end
        PH_IO_REST, PH_M32_REST, PH_M64_RESTHI: begin
          cmd.emit = 1'b0;
          probe_done = 1'b1;
        end
        PH_M64_HI: begin
          cmd.save_high = 1'b1;
          cmd.kind = KIND_WRITE;
          cmd.osel = OSEL_BAR;
          cmd.wsel = WSEL_ONES;
          phase_next = PH_M64_SETLO;
        end
        PH_M64_SETLO: begin
          cmd.kind = KIND_WRITE;
          cmd.osel = OSEL_BAR4;
          cmd.wsel = WSEL_ONES;
          phase_next = PH_M64_SETHI;
        end
        PH_M64_SETHI: begin
          cmd.osel = OSEL_BAR;
          phase_next = PH_M64_READLO;
        end
        PH_M64_READLO: begin
          cmd.size_m64lo = 1'b1;
          cmd.osel = OSEL_BAR4;
          phase_next = PH_M64_READHI;
        end
        PH_M64_READHI: begin
          cmd.size_m64hi = 1'b1;
          cmd.kind = KIND_WRITE;
          cmd.osel = OSEL_BAR;
          cmd.wsel = WSEL_SAVED_LO;
          phase_next = PH_M64_RESTLO;
        end
        PH_M64_RESTLO: begin
          cmd.kind = KIND_WRITE;
          cmd.osel = OSEL_BAR4;
          cmd.wsel = WSEL_SAVED_HI;
          phase_next = PH_M64_RESTHI;
        end
        PH_AS_READ: begin
          if (st.data_io) begin
            cmd.emit = 1'b0;
            advs = 1'b1;
          end else begin
            cmd.kind = KIND_WRITE;
            cmd.osel = OSEL_BAR;
            cmd.wsel = WSEL_ALIGN_LO;
            phase_next = PH_AS_WLO;
          end
        end
        PH_AS_WLO: begin
          cmd.osel = OSEL_BAR;
          phase_next = PH_AS_TYPE;
        end
        PH_AS_TYPE: begin
          if (st.data_m64) begin
            cmd.kind = KIND_WRITE;
            cmd.osel = OSEL_BAR4;
            cmd.wsel = WSEL_ALIGN_HI;
            phase_next = PH_AS_WHI;
          end else begin
            cmd.emit = 1'b0;
            commit = 1'b1;
          end
        end
        PH_AS_WHI: begin
          cmd.emit = 1'b0;
          commit = 1'b1;
        end
        PH_CMD_READ: begin
          cmd.kind = KIND_WRITE;
          cmd.osel = OSEL_CMD;
          cmd.wsel = WSEL_CMD_OR;
          phase_next = PH_CMD_WRITE;
        end
        PH_CMD_WRITE: begin
          cmd.emit = 1'b0;
          nfn = 1'b1;
        end
        default: begin
          cmd.emit = 1'b0;
          phase_next = PH_IDLE;
        end
      endcase

      // Shared tails of the walk: probe done, allocation, BAR step, next
      // function and next device, resolved in that order.
      if (probe_done) begin
        if (st.size_nz) begin
          cmd.emit = 1'b1;
          cmd.osel = OSEL_BAR;
          phase_next = PH_AS_READ;
        end else begin
          advs = 1'b1;
        end
      end
      if (commit) begin
        cmd.ptr_commit = 1'b1;
        advs = 1'b1;
      end
      if (adv4 || advs) begin
        aend = adv4 ? st.end4 : st.end_saved;
        cmd.emit = 1'b1;
        if (aend) begin
          cmd.osel = OSEL_CMD;
          phase_next = PH_CMD_READ;
        end else begin
          cmd.bar_adv = 1'b1;
          cmd.bar_step8 = advs && st.step8;
          cmd.osel = OSEL_BAR;
          phase_next = PH_BAR_READ;
        end
      end
      if (nfn) begin
        if (st.last_fn) begin
          ndev = 1'b1;
        end else begin
          cmd.fn_next = 1'b1;
          cmd.emit = 1'b1;
          phase_next = PH_FN_VID;
        end
      end
      if (ndev) begin
        if (st.last_dev) begin
          cmd.finish = 1'b1;
          phase_next = PH_IDLE;
        end else begin
          cmd.dev_next = 1'b1;
          cmd.emit = 1'b1;
          phase_next = PH_DEV_VID;
        end
      end
    end
    if (!act) begin
      cmd.start = 1'b0;
      cmd.dev_next = 1'b0;
      cmd.fn_next = 1'b0;
      cmd.fn_clear = 1'b0;
      cmd.mf_load = 1'b0;
      cmd.bar_first = 1'b0;
      cmd.bar_adv = 1'b0;
      cmd.save_low = 1'b0;
      cmd.save_high = 1'b0;
      cmd.size_io = 1'b0;
      cmd.size_m32 = 1'b0;
      cmd.size_m64lo = 1'b0;
      cmd.size_m64hi = 1'b0;
      cmd.ptr_commit = 1'b0;
      cmd.emit = 1'b0;
      cmd.finish = 1'b0;
    end
  end

endmodule
`default_nettype wire

### src/pces_dpath.sv
// ----------------------------------------------------------------------------
// PCI config enumeration datapath
// Counters, BAR probe registers, allocation pointer, config registers and
// the output word register.
// ----------------------------------------------------------------------------
`default_nettype none
module pces_dpath #(
  parameter int DEVICES_PER_BUS      = 32,
  parameter int FUNCTIONS_PER_DEVICE = 8,
  parameter int BARS_PER_FUNCTION    = 6
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [63:0]    cfg_data,
  input  wire logic [31:0]    read_data,
  input  wire pces_pkg::cmd_t cmd,
  output pces_pkg::stat_t     st,
  input  wire logic           out_stall,
  output logic                out_valid,
  output logic [1:0]          access_kind,
  output logic [63:0]         access_address,
  output logic [31:0]         write_data,
  output logic [63:0]         next_free_address
);
  import pces_pkg::*;

  localparam logic [6:0] BAR_LIMIT = 7'(16 + 4 * BARS_PER_FUNCTION);
  localparam logic [5:0] DEV_LIMIT = 6'(DEVICES_PER_BUS);
  localparam logic [3:0] FN_LIMIT  = 4'(FUNCTIONS_PER_DEVICE);

  logic [7:0]  scan_bus;
  logic [63:0] window_base;
  logic [63:0] alloc_start;
  logic [4:0]  dev;
  logic [2:0]  fn;
  logic        multi;
  logic [5:0]  bar;
  logic [31:0] saved_low, saved_high;
  logic [63:0] bar_size, size_mask, aligned, aligned_end, ptr;

  logic [4:0]  dev_next;
  logic [2:0]  fn_next;
  logic [5:0]  bar_next;
  logic [63:0] ptr_next;
  logic [11:0] off;
  logic [31:0] wdata;
  logic [6:0]  bar_plus4, bar_plus_s;
  logic [31:0] io_r, m32_r;

  assign st.vid_absent = read_data[15:0] == VID_NONE;
  assign st.data_zero  = read_data == 32'd0;
  assign st.data_io    = read_data[0];
  assign st.data_m64   = read_data[2:1] == 2'b10;
  assign st.hdr_multi  = read_data[23];
  assign st.last_dev   = ({1'b0, dev} + 6'd1) >= DEV_LIMIT;
  assign st.last_fn    = ({1'b0, fn} + 4'd1) >= (multi ? FN_LIMIT : 4'd1);
  assign st.step8      = !saved_low[0] && saved_low[2:1] == 2'b10;
  assign bar_plus4     = {1'b0, bar} + 7'd4;
  assign bar_plus_s    = {1'b0, bar} + (st.step8 ? 7'd8 : 7'd4);
  assign st.end4       = bar_plus4 >= BAR_LIMIT;
  assign st.end_saved  = bar_plus_s >= BAR_LIMIT;
  assign st.size_nz    = bar_size != 64'd0;

  assign io_r  = ~(read_data & IO_MASK) + 32'd1;
  assign m32_r = ~(read_data & MEM_MASK) + 32'd1;

  always_comb begin
    dev_next = dev;
    fn_next  = fn;
    bar_next = bar;
    ptr_next = ptr;
    if (cmd.start) begin
      dev_next = '0;
      fn_next  = '0;
      bar_next = BAR_FIRST;
      ptr_next = alloc_start;
    end
    if (cmd.dev_next) begin
      dev_next = dev + 5'd1;
      fn_next  = '0;
    end
    if (cmd.fn_next) fn_next = fn + 3'd1;
    if (cmd.fn_clear) fn_next = '0;
    if (cmd.bar_first) bar_next = BAR_FIRST;
    if (cmd.bar_adv) bar_next = cmd.bar_step8 ? bar_plus_s[5:0] : bar_plus4[5:0];
    if (cmd.ptr_commit) ptr_next = aligned_end;
    case (cmd.osel)
      OSEL_ZERO: off = 12'd0;
      OSEL_HDR:  off = OFF_HDR;
      OSEL_CMD:  off = OFF_CMD;
      OSEL_BAR:  off = {6'd0, bar_next};
      OSEL_BAR4: off = {5'd0, bar_plus4};
      default:   off = 12'd0;
    endcase
    case (cmd.wsel)
      WSEL_ONES:     wdata = ALL_ONES;
      WSEL_SAVED_LO: wdata = saved_low;
      WSEL_SAVED_HI: wdata = saved_high;
      WSEL_ALIGN_LO: wdata = aligned[31:0];
      WSEL_ALIGN_HI: wdata = aligned[63:32];
      WSEL_CMD_OR:   wdata = read_data | CMD_ENABLES;
      default:       wdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_bus    <= '0;
      window_base <= '0;
      alloc_start <= ALLOC_RESET;
      dev         <= '0;
      fn          <= '0;
      multi       <= 1'b0;
      bar         <= BAR_FIRST;
      saved_low   <= '0;
      saved_high  <= '0;
      bar_size    <= '0;
      ptr         <= ALLOC_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SCAN_BUS:   scan_bus <= cfg_data[7:0];
          REG_ECAM_BASE:  window_base <= cfg_data;
          REG_ALLOC_BASE: alloc_start <= cfg_data;
          default: ;
        endcase
      end
      dev <= dev_next;
      fn  <= fn_next;
      bar <= bar_next;
      ptr <= ptr_next;
      if (cmd.start || cmd.dev_next) multi <= 1'b0;
      if (cmd.mf_load) multi <= st.hdr_multi;
      if (cmd.save_low) saved_low <= read_data;
      if (cmd.save_high) saved_high <= read_data;
      if (cmd.size_io) bar_size <= {32'd0, io_r};
      if (cmd.size_m32) bar_size <= {32'd0, m32_r};
      if (cmd.size_m64lo) bar_size <= {32'd0, read_data & MEM_MASK};
      if (cmd.size_m64hi) bar_size <= ~{read_data, bar_size[31:0]} + 64'd1;
      if (cmd.emit || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The alignment terms settle over the cycles between a size probe and
  // its use, since every access waits for its completion word.
  always_ff @(posedge clk) begin
    size_mask   <= bar_size - 64'd1;
    aligned     <= (ptr + size_mask) & ~size_mask;
    aligned_end <= aligned + bar_size;
    if (cmd.emit || cmd.finish) begin
      access_kind       <= cmd.finish ? KIND_FINISH : cmd.kind;
      access_address    <= cmd.finish ? 64'd0 :
                           window_base + {36'd0, scan_bus, dev_next, fn_next, off};
      write_data        <= (!cmd.finish && cmd.kind == KIND_WRITE) ? wdata : 32'd0;
      next_free_address <= ptr_next;
    end
  end

endmodule
`default_nettype wire

### src/pci_config_enumeration_sequencer.sv
// ----------------------------------------------------------------------------
// PCI config enumeration sequencer
// Walks one bus through ECAM accesses, sizing and assigning memory BARs.
// ----------------------------------------------------------------------------
// One input word is taken at a time: a start word or the completion of the
// access last issued. Each accepted word yields at most one output word in the
// cycle after, and the input stalls while that output word is held, so the
// pace is one access per round trip of the configuration bus and the output
// register handshake. There is no clearing pass after reset.
`default_nettype none
module pci_config_enumeration_sequencer #(
  parameter int DEVICES_PER_BUS      = 32,
  parameter int FUNCTIONS_PER_DEVICE = 8,
  parameter int BARS_PER_FUNCTION    = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [31:0] read_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       access_kind,
  output logic [63:0]      access_address,
  output logic [31:0]      write_data,
  output logic [63:0]      next_free_address
);
  import pces_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  act;

  assign in_stall = out_valid;
  assign act      = in_valid && !in_stall;

  pces_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .act       (act),
    .operation (operation),
    .st        (st),
    .cmd       (cmd)
  );

  pces_dpath #(
    .DEVICES_PER_BUS      (DEVICES_PER_BUS),
    .FUNCTIONS_PER_DEVICE (FUNCTIONS_PER_DEVICE),
    .BARS_PER_FUNCTION    (BARS_PER_FUNCTION)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .read_data         (read_data),
    .cmd               (cmd),
    .st                (st),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .access_kind       (access_kind),
    .access_address    (access_address),
    .write_data        (write_data),
    .next_free_address (next_free_address)
  );

endmodule
`default_nettype wire
